>>> rtl/core/brms_pkg.sv
// Shared types and codes for the banked register file: word type, request and mode
// codes, slot codes and the access request structs between sequencer and memories.
// No dependencies.
package brms_pkg;

  typedef logic [31:0] word_t;

  // register number of the link register and the program counter
  localparam logic [3:0] LR_IDX = 4'd14;
  localparam logic [3:0] PC_IDX = 4'd15;

  // request codes on in_mode
  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_SWITCH,
    OP_RETURN,
    OP_IRQ,
    OP_SWI,
    OP_WR_SPSR,
    OP_WR_STATUS
  } op_t;

  // processor mode codes
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // bank slot of a processor mode (user and system share one slot)
  typedef enum logic [2:0] {
    SLOT_USR,
    SLOT_FIQ,
    SLOT_IRQ,
    SLOT_SVC,
    SLOT_ABT,
    SLOT_UND
  } slot_t;

  // register file read request: logical register in a given bank slot
  typedef struct packed {
    logic       en;
    slot_t      slot;
    logic [3:0] idx;
  } reg_rd_req_t;

  // register file write request
  typedef struct packed {
    logic       en;
    slot_t      slot;
    logic [3:0] idx;
    word_t      data;
  } reg_wr_req_t;

  // saved status read request
  typedef struct packed {
    logic  en;
    slot_t slot;
  } sp_rd_req_t;

  // saved status write request
  typedef struct packed {
    logic  en;
    slot_t slot;
    word_t data;
  } sp_wr_req_t;

endpackage

>>> rtl/core/banked_register_mode_switch.sv
// Banked register file with mode switching. A request is registered, executed, and its
// result registered in the out_ stage; a new one waits for idle and an empty skid entry.
// Irq and swi entry add a pc write state; r14 and pc go through the single write port.
// Reset (rst_n, synchronous, active low): status 0xD3, saved status 0, registers read
// as zero and the pc as 4 through per-entry valid bits; no clearing pass, ready at once.
// Depends on brms_pkg, brms_reg_ram and brms_spsr_ram.
module banked_register_mode_switch
  import brms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  input  logic [4:0]  in_target_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_value,
  output logic [31:0] out_status_word,
  output logic [31:0] out_saved_status_word,
  output logic        out_bad_mode
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PCWR
  } state_t;

  typedef struct packed {
    logic  known;
    slot_t slot;
  } slot_info_t;

  typedef struct packed {
    word_t read_value;
    word_t status_word;
    word_t saved_status_word;
    logic  bad_mode;
  } res_t;

  localparam word_t      STATUS_MASK = 32'hF800_00FF;
  localparam word_t      STATUS_RST  = 32'h0000_00D3;
  localparam word_t      IRQ_VECTOR  = 32'h0000_001C;
  localparam word_t      SWI_VECTOR  = 32'h0000_000C;
  localparam int         T_POS       = 5;
  localparam int         I_POS       = 7;

  // decode a mode code into its bank slot
  function automatic slot_info_t mode_slot(input logic [4:0] m);
    slot_info_t s;
    s.known = 1'b1;
    s.slot  = SLOT_USR;
    case (m)
      MODE_USR, MODE_SYS: s.slot = SLOT_USR;
      MODE_FIQ:           s.slot = SLOT_FIQ;
      MODE_IRQ:           s.slot = SLOT_IRQ;
      MODE_SVC:           s.slot = SLOT_SVC;
      MODE_ABT:           s.slot = SLOT_ABT;
      MODE_UND:           s.slot = SLOT_UND;
      default:            s.known = 1'b0;
    endcase
    return s;
  endfunction

  state_t      state_r;
  op_t         req_op_r;
  logic [3:0]  req_idx_r;
  word_t       req_val_r;
  logic [4:0]  req_tm_r;
  word_t       status_r;
  word_t       lssr_r;
  res_t        out_r;
  res_t        hold_r;
  logic        out_valid_r;
  logic        hold_valid_r;

  logic        accept;
  op_t         in_op;
  slot_info_t  cur_info;
  slot_info_t  acc_info;
  slot_info_t  tgt_info;
  reg_rd_req_t reg_rd;
  reg_wr_req_t reg_wr;
  sp_rd_req_t  sp_rd;
  sp_wr_req_t  sp_wr;
  word_t       reg_rdata;
  word_t       sp_rdata;
  word_t       reloaded;
  word_t       status_nxt;
  word_t       lssr_nxt;
  res_t        res;
  logic        produce;

  assign in_op    = op_t'(in_mode);
  assign in_ready = (state_r == ST_IDLE) && !hold_valid_r;
  assign accept   = in_valid && in_ready;
  assign cur_info = mode_slot(status_r[4:0]);
  assign produce  = (state_r == ST_EXEC);

  // reads issued at the accepting edge
  assign acc_info = (in_op == OP_RETURN) ? mode_slot(lssr_r[4:0])
                                         : mode_slot(in_write_value[4:0]);
  always_comb begin
    reg_rd.en   = accept;
    reg_rd.slot = cur_info.slot;
    reg_rd.idx  = (in_op == OP_READ) ? in_reg_index : PC_IDX;
    sp_rd.en    = accept;
    sp_rd.slot  = acc_info.slot;
  end

  brms_reg_ram u_reg_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (reg_rd),
    .wr_req  (reg_wr),
    .rd_data (reg_rdata)
  );

  brms_spsr_ram u_spsr_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (sp_rd),
    .wr_req  (sp_wr),
    .rd_data (sp_rdata)
  );

  // target slot of the operation in flight
  always_comb begin
    case (req_op_r)
      OP_RETURN:    tgt_info = mode_slot(lssr_r[4:0]);
      OP_WR_STATUS: tgt_info = mode_slot(req_val_r[4:0]);
      default:      tgt_info = mode_slot(req_tm_r);
    endcase
  end

  // saved status of the new mode, forwarded when it is the entry just written back
  assign reloaded = (tgt_info.slot == cur_info.slot) ? lssr_r : sp_rdata;

  // execute: modify state and write back
  always_comb begin
    status_nxt     = status_r;
    lssr_nxt       = lssr_r;
    res.read_value = '0;
    res.bad_mode   = 1'b0;
    reg_wr.en      = 1'b0;
    reg_wr.slot    = cur_info.slot;
    reg_wr.idx     = req_idx_r;
    reg_wr.data    = req_val_r;
    sp_wr.en       = 1'b0;
    sp_wr.slot     = cur_info.slot;
    sp_wr.data     = lssr_r;
    if (state_r == ST_EXEC) begin
      case (req_op_r)
        OP_READ: begin
          res.read_value = reg_rdata;
        end
        OP_WRITE: begin
          reg_wr.en = 1'b1;
        end
        OP_SWITCH: begin
          if (!tgt_info.known) begin
            res.bad_mode = 1'b1;
          end else begin
            sp_wr.en         = 1'b1;
            lssr_nxt         = status_r;
            status_nxt[4:0]  = req_tm_r;
          end
        end
        OP_RETURN: begin
          if (!tgt_info.known) begin
            res.bad_mode = 1'b1;
          end else begin
            sp_wr.en   = 1'b1;
            status_nxt = lssr_r & STATUS_MASK;
            if (tgt_info.slot != SLOT_USR) begin
              lssr_nxt = reloaded;
            end
          end
        end
        OP_IRQ, OP_SWI: begin
          sp_wr.en          = 1'b1;
          lssr_nxt          = status_r;
          status_nxt[4:0]   = (req_op_r == OP_IRQ) ? MODE_IRQ : MODE_SVC;
          status_nxt[T_POS] = 1'b0;
          status_nxt[I_POS] = 1'b1;
          reg_wr.en         = 1'b1;
          reg_wr.idx        = LR_IDX;
          if (req_op_r == OP_IRQ) begin
            reg_wr.slot = SLOT_IRQ;
            reg_wr.data = reg_rdata + (status_r[T_POS] ? 32'd2 : 32'd0);
          end else begin
            reg_wr.slot = SLOT_SVC;
            reg_wr.data = reg_rdata - (status_r[T_POS] ? 32'd2 : 32'd4);
          end
        end
        OP_WR_SPSR: begin
          lssr_nxt = req_val_r & STATUS_MASK;
        end
        OP_WR_STATUS: begin
          if (!tgt_info.known) begin
            res.bad_mode = 1'b1;
          end else begin
            if (req_val_r[4:0] != status_r[4:0]) begin
              sp_wr.en = 1'b1;
              if (tgt_info.slot != SLOT_USR) begin
                lssr_nxt = reloaded;
              end
            end
            status_nxt = req_val_r & STATUS_MASK;
          end
        end
        default: begin
          res.bad_mode = 1'b0;
        end
      endcase
    end else if (state_r == ST_PCWR) begin
      // second write of an exception entry: pc takes the vector
      reg_wr.en   = 1'b1;
      reg_wr.idx  = PC_IDX;
      reg_wr.data = (req_op_r == OP_IRQ) ? IRQ_VECTOR : SWI_VECTOR;
    end
    res.status_word       = status_nxt;
    res.saved_status_word = lssr_nxt;
  end

  // sequencer, architectural status and output skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      status_r     <= STATUS_RST;
      lssr_r       <= '0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r   <= ST_EXEC;
            req_op_r  <= in_op;
            req_idx_r <= in_reg_index;
            req_val_r <= in_write_value;
            req_tm_r  <= in_target_mode;
          end
        end
        ST_EXEC: begin
          status_r <= status_nxt;
          lssr_r   <= lssr_nxt;
          state_r  <= (req_op_r == OP_IRQ || req_op_r == OP_SWI) ? ST_PCWR : ST_IDLE;
        end
        ST_PCWR: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (!out_valid_r || out_ready) begin
        if (hold_valid_r) begin
          out_r        <= hold_r;
          out_valid_r  <= 1'b1;
          hold_valid_r <= 1'b0;
        end else if (produce) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (produce) begin
        hold_r       <= res;
        hold_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_read_value        = out_r.read_value;
  assign out_status_word       = out_r.status_word;
  assign out_saved_status_word = out_r.saved_status_word;
  assign out_bad_mode          = out_r.bad_mode;

  // skid entry only fills behind a waiting result
  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output stage");

  // the live status always names a known mode
  a_status_mode_known: assert property (@(posedge clk) disable iff (!rst_n)
    cur_info.known)
    else $error("status holds an unknown mode code");

  // an accepted request is executed on the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC)
    else $error("accepted request not executed");

  // pc write only follows the execute cycle of an exception entry
  a_pcwr_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PCWR |-> $past(state_r) == ST_EXEC &&
                           (req_op_r == OP_IRQ || req_op_r == OP_SWI))
    else $error("pc write outside exception entry");

endmodule

>>> rtl/core/brms_reg_ram.sv
// Physical register memory: 31 entries holding shared, user, fast irq and
// per-mode r13/r14 registers plus the pc. Depends on brms_pkg.
// One write and one registered read per cycle; per-entry valid bits give reset values.
module brms_reg_ram
  import brms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  reg_rd_req_t rd_req,
  input  reg_wr_req_t wr_req,
  output word_t       rd_data
);

  localparam int          REG_DEPTH = 31;
  localparam int          REG_AW    = 5;
  localparam logic [4:0]  PC_ADDR   = 5'd30;
  localparam logic [4:0]  FIQ_OFS   = 5'd5;
  localparam logic [4:0]  SP_BASE   = 5'd18;
  localparam word_t       PC_RESET  = 32'h0000_0004;

  // map a logical register of a bank slot to its physical entry
  function automatic logic [REG_AW-1:0] phys_addr(input slot_t slot, input logic [3:0] idx);
    logic [REG_AW-1:0] a;
    a = {1'b0, idx};
    case (idx) inside
      [4'd0:4'd7]: begin
        a = {1'b0, idx};
      end
      [4'd8:4'd12]: begin
        a = (slot == SLOT_FIQ) ? ({1'b0, idx} + FIQ_OFS) : {1'b0, idx};
      end
      [4'd13:4'd14]: begin
        a = SP_BASE + {1'b0, slot, 1'b0} + {4'b0000, ~idx[0]};
      end
      default: begin
        a = PC_ADDR;
      end
    endcase
    return a;
  endfunction

  logic [31:0]          ram_r [REG_DEPTH];
  logic [REG_DEPTH-1:0] vld_r;
  logic [REG_AW-1:0]    rd_addr;
  logic [REG_AW-1:0]    wr_addr;
  word_t                rdata_r;
  logic                 rvld_r;
  logic                 rpc_r;

  assign rd_addr = phys_addr(rd_req.slot, rd_req.idx);
  assign wr_addr = phys_addr(wr_req.slot, wr_req.idx);

  // storage array
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      ram_r[wr_addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      rdata_r <= ram_r[rd_addr];
    end
  end

  // entry valid bits and read-side flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
      rpc_r  <= 1'b0;
    end else begin
      if (wr_req.en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rvld_r <= vld_r[rd_addr];
        rpc_r  <= (rd_addr == PC_ADDR);
      end
    end
  end

  // unwritten entries read as their reset value
  assign rd_data = rvld_r ? rdata_r : (rpc_r ? PC_RESET : '0);

endmodule

>>> rtl/core/brms_spsr_ram.sv
// Saved status memory: one entry per exception mode (fiq, irq, svc, abt, und).
// Depends on brms_pkg. Registered read, per-entry valid bits for the zero reset.
module brms_spsr_ram
  import brms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sp_rd_req_t rd_req,
  input  sp_wr_req_t wr_req,
  output word_t      rd_data
);

  localparam int SP_DEPTH = 5;
  localparam int SP_AW    = 3;

  logic [31:0]         ram_r [SP_DEPTH];
  logic [SP_DEPTH-1:0] vld_r;
  logic [SP_AW-1:0]    rd_idx;
  logic [SP_AW-1:0]    wr_idx;
  logic                rd_en;
  logic                wr_en;
  word_t               rdata_r;
  logic                rvld_r;

  // user and system modes have no entry
  assign rd_idx = SP_AW'(rd_req.slot) - SP_AW'(1);
  assign wr_idx = SP_AW'(wr_req.slot) - SP_AW'(1);
  assign rd_en  = rd_req.en && (rd_req.slot != SLOT_USR);
  assign wr_en  = wr_req.en && (wr_req.slot != SLOT_USR);

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram_r[wr_idx] <= wr_req.data;
    end
    if (rd_en) begin
      rdata_r <= ram_r[rd_idx];
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for banked_register_mode_switch: a directed table, then random requests,
// checked against a cycle-free predictor of the register banks or the typed table rows.
// Depends on brms_pkg and the banked_register_mode_switch RTL.
module tb
  import brms_pkg::*;
();

  localparam word_t STATUS_MASK = 32'hF800_00FF;
  localparam word_t IRQ_VECTOR = 32'h0000_001C;
  localparam word_t SWI_VECTOR = 32'h0000_000C;
  localparam int T_POS = 5;
  localparam int I_POS = 7;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM = 1800;

  typedef struct packed {
    word_t rd;
    word_t st;
    word_t sv;
    logic  bad;
  } result_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
    word_t      val;
    logic [4:0] tm;
    logic       typed;
    result_t    res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_mode;
  logic [3:0]  in_reg_index;
  logic [31:0] in_write_value;
  logic [4:0]  in_target_mode;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_value;
  logic [31:0] out_status_word;
  logic [31:0] out_saved_status_word;
  logic        out_bad_mode;

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      burst_left = 0;
  int      cycle_count = 0;

  // predictor state: visible registers and the banks behind them
  word_t gpr [16];
  word_t usr_lo [5];
  word_t fiq_regs [7];
  word_t pair_regs [6][2];
  word_t spsr_bank [6];
  word_t cur_spsr;
  word_t cpsr;

  banked_register_mode_switch i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_mode               (in_mode),
    .in_reg_index          (in_reg_index),
    .in_write_value        (in_write_value),
    .in_target_mode        (in_target_mode),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_read_value        (out_read_value),
    .out_status_word       (out_status_word),
    .out_saved_status_word (out_saved_status_word),
    .out_bad_mode          (out_bad_mode)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // directed requests; typed results only where obvious from reset state
  row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_READ,      4'd15, 32'h0,         5'h0,     1'b1, '{32'd4, 32'hD3, 32'h0, 1'b0}},
    '{OP_WRITE,     4'd0,  32'hFFFF_FFFF, 5'h0,     1'b1, '{32'd0, 32'hD3, 32'h0, 1'b0}},
    '{OP_READ,      4'd0,  32'h0,         5'h0,     1'b1,
      '{32'hFFFF_FFFF, 32'hD3, 32'h0, 1'b0}},
    '{OP_WRITE,     4'd15, 32'h0,         5'h0,     1'b1, '{32'd0, 32'hD3, 32'h0, 1'b0}},
    '{OP_SWI,       4'd0,  32'h0,         5'h0,     1'b0, '0},
    '{OP_READ,      4'd14, 32'h0,         5'h0,     1'b0, '0},
    '{OP_SWITCH,    4'd0,  32'h0,         5'h00,    1'b1, '{32'd0, 32'hD3, 32'hD3, 1'b1}},
    '{OP_SWITCH,    4'd0,  32'h0,         5'h14,    1'b0, '0},
    '{OP_WR_STATUS, 4'd0,  32'hFFFF_FF00, 5'h0,     1'b0, '0},
    '{OP_WR_SPSR,   4'd0,  32'hFFFF_FFFF, 5'h0,     1'b1,
      '{32'd0, 32'hD3, 32'hF800_00FF, 1'b0}},
    '{OP_RETURN,    4'd0,  32'h0,         5'h0,     1'b0, '0},
    '{OP_WRITE,     4'd8,  32'h1234_5678, 5'h0,     1'b0, '0},
    '{OP_SWITCH,    4'd0,  32'h0,         MODE_FIQ, 1'b0, '0},
    '{OP_WRITE,     4'd8,  32'hA5A5_A5A5, 5'h0,     1'b0, '0},
    '{OP_WRITE,     4'd15, 32'hFFFF_FFFF, 5'h0,     1'b0, '0},
    '{OP_IRQ,       4'd0,  32'h0,         5'h0,     1'b0, '0},
    '{OP_READ,      4'd14, 32'h0,         5'h0,     1'b0, '0},
    '{OP_RETURN,    4'd0,  32'h0,         5'h0,     1'b0, '0},
    '{OP_READ,      4'd8,  32'h0,         5'h0,     1'b0, '0},
    '{OP_SWITCH,    4'd0,  32'h0,         MODE_ABT, 1'b0, '0},
    '{OP_SWITCH,    4'd0,  32'h0,         MODE_UND, 1'b0, '0},
    '{OP_SWITCH,    4'd0,  32'h0,         MODE_USR, 1'b0, '0},
    '{OP_WR_STATUS, 4'd0,  32'h0FFF_FF13, 5'h0,     1'b0, '0},
    '{OP_WR_SPSR,   4'd0,  32'h0,         5'h0,     1'b0, '0},
    '{OP_RETURN,    4'd0,  32'h0,         5'h0,     1'b0, '0}
  };

  function automatic logic known_mode(logic [4:0] m);
    return m inside {MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};
  endfunction

  function automatic slot_t slot_of(logic [4:0] m);
    case (m)
      MODE_FIQ: return SLOT_FIQ;
      MODE_IRQ: return SLOT_IRQ;
      MODE_SVC: return SLOT_SVC;
      MODE_ABT: return SLOT_ABT;
      MODE_UND: return SLOT_UND;
      default:  return SLOT_USR;
    endcase
  endfunction

  task automatic reset_banks();
    foreach (gpr[i]) gpr[i] = '0;
    gpr[PC_IDX] = 32'd4;
    foreach (usr_lo[i]) usr_lo[i] = '0;
    foreach (fiq_regs[i]) fiq_regs[i] = '0;
    foreach (pair_regs[i, j]) pair_regs[i][j] = '0;
    foreach (spsr_bank[i]) spsr_bank[i] = '0;
    cur_spsr = '0;
    cpsr = 32'hD3;
  endtask

  // park the visible r8..r14 and saved status into the bank of a slot
  function automatic void park_bank(slot_t s);
    if (s == SLOT_FIQ) begin
      for (int i = 0; i < 7; i++) fiq_regs[i] = gpr[8 + i];
    end else begin
      for (int i = 0; i < 5; i++) usr_lo[i] = gpr[8 + i];
      for (int j = 0; j < 2; j++) pair_regs[s][j] = gpr[13 + j];
    end
    if (s != SLOT_USR) spsr_bank[s] = cur_spsr;
  endfunction

  function automatic void fetch_bank(slot_t s);
    if (s == SLOT_FIQ) begin
      for (int i = 0; i < 7; i++) gpr[8 + i] = fiq_regs[i];
    end else begin
      for (int i = 0; i < 5; i++) gpr[8 + i] = usr_lo[i];
      for (int j = 0; j < 2; j++) gpr[13 + j] = pair_regs[s][j];
    end
  endfunction

  // user and system have no saved status bank, the live one is kept
  function automatic void fetch_spsr(slot_t s);
    if (s != SLOT_USR) cur_spsr = spsr_bank[s];
  endfunction

  function automatic void take_mode(logic [4:0] m);
    park_bank(slot_of(cpsr[4:0]));
    cur_spsr = cpsr;
    cpsr[4:0] = m;
    fetch_bank(slot_of(m));
  endfunction

  // register file behavior for one request
  function automatic result_t bank_step(op_t op, logic [3:0] idx, word_t val,
                                        logic [4:0] tm);
    result_t r;
    slot_t   dst;
    r = '0;
    case (op)
      OP_READ: r.rd = gpr[idx];
      OP_WRITE: gpr[idx] = val;
      OP_SWITCH: begin
        if (!known_mode(tm)) r.bad = 1'b1;
        else take_mode(tm);
      end
      OP_RETURN: begin
        if (!known_mode(cur_spsr[4:0])) begin
          r.bad = 1'b1;
        end else begin
          dst = slot_of(cur_spsr[4:0]);
          park_bank(slot_of(cpsr[4:0]));
          cpsr = cur_spsr & STATUS_MASK;
          fetch_bank(dst);
          fetch_spsr(dst);
        end
      end
      OP_IRQ: begin
        take_mode(MODE_IRQ);
        gpr[LR_IDX] = gpr[PC_IDX] + (cpsr[T_POS] ? 32'd2 : 32'd0);
        cpsr[T_POS] = 1'b0;
        cpsr[I_POS] = 1'b1;
        gpr[PC_IDX] = IRQ_VECTOR;
      end
      OP_SWI: begin
        take_mode(MODE_SVC);
        gpr[LR_IDX] = gpr[PC_IDX] - (cpsr[T_POS] ? 32'd2 : 32'd4);
        cpsr[T_POS] = 1'b0;
        cpsr[I_POS] = 1'b1;
        gpr[PC_IDX] = SWI_VECTOR;
      end
      OP_WR_SPSR: cur_spsr = val & STATUS_MASK;
      default: begin
        if (!known_mode(val[4:0])) begin
          r.bad = 1'b1;
        end else begin
          if (val[4:0] != cpsr[4:0]) begin
            dst = slot_of(val[4:0]);
            park_bank(slot_of(cpsr[4:0]));
            fetch_bank(dst);
            fetch_spsr(dst);
          end
          cpsr = val & STATUS_MASK;
        end
      end
    endcase
    r.st = cpsr;
    r.sv = cur_spsr;
    return r;
  endfunction

  function automatic logic [4:0] pick_mode();
    logic [4:0] codes [7];
    codes = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND, MODE_SYS};
    if ($urandom_range(0, 99) < 85) return codes[$urandom_range(0, 6)];
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 7));
      3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // hand one request to the block and record its predicted result
  task automatic send_request(input op_t op, input logic [3:0] idx, input word_t val,
                              input logic [4:0] tm, output result_t pred);
    in_valid <= 1'b1;
    in_mode <= op;
    in_reg_index <= idx;
    in_write_value <= val;
    in_target_mode <= tm;
    do @(posedge clk); while (!in_ready);
    pred = bank_step(op, idx, val, tm);
  endtask

  // sender pacing: bursts of back-to-back requests with random gaps between
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 40);
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver stall pattern, its style following bits 10:9 of the cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count >> 9) & 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 99) < 65);
      2: out_ready <= (cycle_count[2:0] != 3'd0);
      default: out_ready <= (cycle_count[4:0] < 5'd6);
    endcase
  end

  task automatic check_field(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request pending, actual %h %h %h %b", $time,
                 out_read_value, out_status_word, out_saved_status_word, out_bad_mode);
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.rd, out_read_value);
        check_field("status_word", want.st, out_status_word);
        check_field("saved_status_word", want.sv, out_saved_status_word);
        check_field("bad_mode", 32'(want.bad), 32'(out_bad_mode));
      end
    end
  end

  // stimulus
  initial begin
    result_t pred;
    op_t     op;
    int      pick;
    word_t   val;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = '0;
    in_reg_index = '0;
    in_write_value = '0;
    in_target_mode = '0;
    reset_banks();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].val,
                   directed_rows[k].tm, pred);
      pending_results.push_back(directed_rows[k].typed ? directed_rows[k].res : pred);
      pace_sender();
    end

    // random requests, weighted toward register traffic with exception flows mixed in
    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) op = OP_READ;
      else if (pick < 52) op = OP_WRITE;
      else if (pick < 64) op = OP_SWITCH;
      else if (pick < 73) op = OP_RETURN;
      else if (pick < 79) op = OP_IRQ;
      else if (pick < 85) op = OP_SWI;
      else if (pick < 92) op = OP_WR_SPSR;
      else op = OP_WR_STATUS;
      val = pick_word();
      if (op == OP_WR_SPSR || op == OP_WR_STATUS) val[4:0] = pick_mode();
      send_request(op, 4'($urandom_range(0, 15)), val, pick_mode(), pred);
      pending_results.push_back(pred);
      pace_sender();
    end
    in_valid <= 1'b0;

    // drain
    for (int k = 0; k < 20000 && pending_results.size() != 0; k++) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
